// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by wlf_queue_ctrl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define WLF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define WLF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/wlf_pkg.sv
// ----------------------------------------------------------------------------
// wlf_pkg
// Types and constants of the weight limited FIFO with consumer credit.
// ----------------------------------------------------------------------------
package wlf_pkg;

  localparam int MassBits   = 8;
  localparam int LoaderBits = 22;
  localparam int SlotBits   = 5;
  localparam int WideBits   = 16;

  localparam logic [SlotBits-1:0] SlotsRst = 5'd16;
  localparam logic [WideBits-1:0] LimitRst = 16'hFFFF;
  localparam logic [WideBits-1:0] CapRst   = 16'hFFFF;

  localparam logic ModePush = 1'b0;
  localparam logic ModePop  = 1'b1;

  typedef enum logic [1:0] {
    CfgSlots    = 2'd0,
    CfgLimit    = 2'd1,
    CfgCapacity = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StPushed  = 3'd0,
    StRefused = 3'd1,
    StPopped  = 3'd2,
    StEmpty   = 3'd3,
    StSwapped = 3'd4
  } status_e;

  typedef struct packed {
    logic [SlotBits-1:0] slots;
    logic [WideBits-1:0] limit;
    logic [WideBits-1:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic                slots_wr;
    logic                cap_wr;
    logic [WideBits-1:0] value;
  } cfg_evt_t;

  typedef struct packed {
    logic                  mode;
    logic [MassBits-1:0]   item_mass;
    logic [LoaderBits-1:0] loader_id;
  } item_t;

  typedef struct packed {
    logic [MassBits-1:0]   mass;
    logic [LoaderBits-1:0] loader;
  } entry_t;

  typedef struct packed {
    status_e               status;
    logic [MassBits-1:0]   out_mass;
    logic [LoaderBits-1:0] out_loader;
    logic [SlotBits-1:0]   occupancy;
    logic [WideBits-1:0]   held_mass;
    logic [WideBits-1:0]   credit_left;
  } result_t;

endpackage

// File: design/wlf_req_if.sv
// ----------------------------------------------------------------------------
// wlf_req_if
// Request channel: one push or pop request per handshake.
// ----------------------------------------------------------------------------
interface wlf_req_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [wlf_pkg::MassBits-1:0]   item_mass;
  logic [wlf_pkg::LoaderBits-1:0] loader_id;

  modport source (output valid, output mode, output item_mass, output loader_id,
                  input ready);
  modport sink   (input valid, input mode, input item_mass, input loader_id,
                  output ready);
endinterface

// File: design/wlf_rsp_if.sv
// ----------------------------------------------------------------------------
// wlf_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface wlf_rsp_if;
  logic                           valid;
  logic                           ready;
  wlf_pkg::status_e               status;
  logic [wlf_pkg::MassBits-1:0]   out_mass;
  logic [wlf_pkg::LoaderBits-1:0] out_loader;
  logic [wlf_pkg::SlotBits-1:0]   occupancy;
  logic [wlf_pkg::WideBits-1:0]   held_mass;
  logic [wlf_pkg::WideBits-1:0]   credit_left;

  modport source (output valid, output status, output out_mass, output out_loader,
                  output occupancy, output held_mass, output credit_left,
                  input ready);
  modport sink   (input valid, input status, input out_mass, input out_loader,
                  input occupancy, input held_mass, input credit_left,
                  output ready);
endinterface

// File: design/wlf_ring_mem.sv
// ----------------------------------------------------------------------------
// wlf_ring_mem
// Ring storage: one write port, one registered read port with write bypass.
// ----------------------------------------------------------------------------
module wlf_ring_mem #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  wlf_pkg::entry_t      wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output wlf_pkg::entry_t      rdata_o
);

  wlf_pkg::entry_t mem [Depth];
  wlf_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/wlf_queue_ctrl.sv
// ----------------------------------------------------------------------------
// wlf_queue_ctrl
// Queue state and per-request decision: pointers, count, held mass, credit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wlf_queue_ctrl #(
  parameter int Depth = 16,
  parameter int IdxW  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wlf_pkg::cfg_t         cfg_i,
  input  wlf_pkg::cfg_evt_t     cfg_evt_i,
  input  logic                  step_i,
  input  wlf_pkg::item_t        item_i,
  input  wlf_pkg::entry_t       rd_data_i,
  output logic                  wr_en_o,
  output logic [IdxW-1:0]       wr_addr_o,
  output wlf_pkg::entry_t       wr_data_o,
  output logic [IdxW-1:0]       rd_addr_o,
  output wlf_pkg::result_t      result_o
);

  localparam int CmpW = ((IdxW > wlf_pkg::SlotBits) ? IdxW : wlf_pkg::SlotBits) + 1;
  localparam logic [CmpW-1:0] DepthC = CmpW'(Depth);

  logic [IdxW-1:0]              head_q, head_d, tail_q, tail_d, head_adv, tail_adv;
  logic [wlf_pkg::SlotBits-1:0] count_q, count_d;
  logic [wlf_pkg::WideBits-1:0] mass_q, mass_d, credit_q, credit_d, pop_mass;
  logic [CmpW-1:0]              slots_ext, active, head_nxt, tail_nxt;
  logic [wlf_pkg::WideBits:0]   mass_sum;
  logic                         push_ok, pop_fit;

  always_comb begin
    slots_ext = CmpW'(cfg_i.slots);
    if (slots_ext == '0) begin
      active = CmpW'(1);
    end else if (slots_ext > DepthC) begin
      active = DepthC;
    end else begin
      active = slots_ext;
    end

    head_nxt = CmpW'(head_q) + CmpW'(1);
    tail_nxt = CmpW'(tail_q) + CmpW'(1);
    head_adv = (head_nxt >= active) ? '0 : head_nxt[IdxW-1:0];
    tail_adv = (tail_nxt >= active) ? '0 : tail_nxt[IdxW-1:0];

    mass_sum = {1'b0, mass_q} + (wlf_pkg::WideBits + 1)'(item_i.item_mass);
    push_ok  = (CmpW'(count_q) < active) && (mass_sum <= {1'b0, cfg_i.limit});
    pop_mass = wlf_pkg::WideBits'(rd_data_i.mass);
    pop_fit  = pop_mass <= credit_q;

    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    mass_d   = mass_q;
    credit_d = credit_q;
    wr_en_o  = 1'b0;

    result_o            = '0;
    result_o.status     = wlf_pkg::StRefused;

    if (cfg_evt_i.slots_wr || cfg_evt_i.cap_wr) begin
      if (cfg_evt_i.slots_wr) begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
        mass_d  = '0;
      end
      if (cfg_evt_i.cap_wr) begin
        credit_d = cfg_evt_i.value;
      end
    end else if (step_i) begin
      if (item_i.mode == wlf_pkg::ModePush) begin
        if (push_ok) begin
          wr_en_o             = 1'b1;
          tail_d              = tail_adv;
          count_d             = count_q + wlf_pkg::SlotBits'(1);
          mass_d              = mass_sum[wlf_pkg::WideBits-1:0];
          result_o.status     = wlf_pkg::StPushed;
          result_o.out_mass   = item_i.item_mass;
          result_o.out_loader = item_i.loader_id;
        end
      end else if (count_q == '0) begin
        result_o.status = wlf_pkg::StEmpty;
      end else if (pop_fit) begin
        head_d              = head_adv;
        count_d             = count_q - wlf_pkg::SlotBits'(1);
        mass_d              = (mass_q >= pop_mass) ? (mass_q - pop_mass) : '0;
        credit_d            = credit_q - pop_mass;
        result_o.status     = wlf_pkg::StPopped;
        result_o.out_mass   = rd_data_i.mass;
        result_o.out_loader = rd_data_i.loader;
      end else begin
        credit_d        = cfg_i.capacity;
        result_o.status = wlf_pkg::StSwapped;
      end
    end

    result_o.occupancy   = count_d;
    result_o.held_mass   = mass_d;
    result_o.credit_left = credit_d;
  end

  assign wr_addr_o        = tail_q;
  assign wr_data_o.mass   = item_i.item_mass;
  assign wr_data_o.loader = item_i.loader_id;
  assign rd_addr_o        = head_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      mass_q   <= '0;
      credit_q <= wlf_pkg::CapRst;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      mass_q   <= mass_d;
      credit_q <= credit_d;
    end
  end

  `WLF_ASSERT(a_count_in_slots, clk_i, rst_ni, CmpW'(count_q) <= active, "count above slots")
  `WLF_ASSERT(a_credit_in_cap, clk_i, rst_ni, credit_q <= cfg_i.capacity, "credit above capacity")
  `WLF_ASSERT_IMPL(a_empty_no_mass, clk_i, rst_ni, count_q == '0, mass_q == '0, "mass while empty")
  `WLF_ASSERT(a_tail_in_ring, clk_i, rst_ni, CmpW'(tail_q) < active, "tail outside ring")

endmodule

// File: design/weight_limited_fifo_with_consumer_credit.sv
// ----------------------------------------------------------------------------
// weight_limited_fifo_with_consumer_credit
// Ring FIFO of (mass, loader id) items bounded by slot count and total mass,
// drained against a consumer credit that reloads on a swap.
// ----------------------------------------------------------------------------
// The block accepts one request per cycle while the response side does not stall
// it. A taken request sits in the input register until the queue state is
// updated, then the result register holds its outcome until it is accepted.
// Pointers, counters and credit update together, with the head entry of the
// ring memory read ahead through its registered port from the next head
// pointer. The ring contents are not cleared after reset or on a slot count
// write; only written entries are ever popped. Configuration writes go through
// cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must make them only while no
// request is in flight, as the block does not enforce it. Writing the slot
// count empties the queue and writing the capacity reloads the credit.
// ----------------------------------------------------------------------------
module weight_limited_fifo_with_consumer_credit #(
  parameter int RING_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [wlf_pkg::WideBits-1:0]  cfg_wdata_i,
  wlf_req_if.sink                       req_i,
  wlf_rsp_if.source                     rsp_o
);

  localparam int IdxW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  wlf_pkg::cfg_t     cfg_q;
  wlf_pkg::cfg_evt_t cfg_evt;
  wlf_pkg::item_t    item_q;
  wlf_pkg::result_t  result, result_q;
  wlf_pkg::entry_t   wr_data, rd_data;
  logic [IdxW-1:0]   wr_addr, rd_addr;
  logic              wr_en, in_valid_q, out_valid_q, step;

  always_comb begin
    cfg_evt.slots_wr = cfg_we_i && (cfg_idx_i == wlf_pkg::CfgSlots);
    cfg_evt.cap_wr   = cfg_we_i && (cfg_idx_i == wlf_pkg::CfgCapacity);
    cfg_evt.value    = cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slots    <= wlf_pkg::SlotsRst;
      cfg_q.limit    <= wlf_pkg::LimitRst;
      cfg_q.capacity <= wlf_pkg::CapRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wlf_pkg::CfgSlots:    cfg_q.slots    <= cfg_wdata_i[wlf_pkg::SlotBits-1:0];
        wlf_pkg::CfgLimit:    cfg_q.limit    <= cfg_wdata_i;
        wlf_pkg::CfgCapacity: cfg_q.capacity <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign step        = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      item_q.mode      <= req_i.mode;
      item_q.item_mass <= req_i.item_mass;
      item_q.loader_id <= req_i.loader_id;
    end
    if (step) begin
      result_q <= result;
    end
  end

  wlf_queue_ctrl #(
    .Depth (RING_DEPTH),
    .IdxW  (IdxW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .cfg_evt_i (cfg_evt),
    .step_i    (step),
    .item_i    (item_q),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_addr_o (rd_addr),
    .result_o  (result)
  );

  wlf_ring_mem #(
    .Depth (RING_DEPTH),
    .AddrW (IdxW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = result_q.status;
  assign rsp_o.out_mass    = result_q.out_mass;
  assign rsp_o.out_loader  = result_q.out_loader;
  assign rsp_o.occupancy   = result_q.occupancy;
  assign rsp_o.held_mass   = result_q.held_mass;
  assign rsp_o.credit_left = result_q.credit_left;

endmodule

// File: dv/wlf_fifo_checker.sv
// ----------------------------------------------------------------------------
// wlf_fifo_checker
// Watches the request, response and register ports of the weight limited
// FIFO, keeps a shadow of its ring, counters and credit, works out the result
// of every accepted request and compares each response with it in order.
// ----------------------------------------------------------------------------
module wlf_fifo_checker
  import wlf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [WideBits-1:0] cfg_wdata_i,
  wlf_req_if                  req_mon,
  wlf_rsp_if                  rsp_mon,
  output int                  errors_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RingDepth = 16;

  typedef logic [$clog2(RingDepth)-1:0] slot_idx_t;

  cfg_t                regs;
  entry_t              shadow_ring [RingDepth];
  slot_idx_t           head_slot;
  slot_idx_t           tail_slot;
  logic [SlotBits-1:0] item_count;
  logic [WideBits-1:0] held_total;
  logic [WideBits-1:0] credit;
  result_t             due_results [$];
  int                  errors = 0;

  assign errors_o = errors;

  function automatic logic [SlotBits-1:0] usable_slots(input logic [SlotBits-1:0] slots);
    if (slots == '0) return SlotBits'(1);
    if (slots > SlotBits'(RingDepth)) return SlotBits'(RingDepth);
    return slots;
  endfunction

  function automatic slot_idx_t next_slot(input slot_idx_t idx);
    if (SlotBits'(idx) + SlotBits'(1) >= usable_slots(regs.slots)) return '0;
    return idx + 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t     oldest;
    result_t     outcome;
    entry_t      head_item;
    logic [16:0] mass_sum;
    if (!rst_ni) begin
      regs       = '{slots: SlotsRst, limit: LimitRst, capacity: CapRst};
      head_slot  = '0;
      tail_slot  = '0;
      item_count = '0;
      held_total = '0;
      credit     = CapRst;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("response with no request outstanding", 32'(rsp_mon.status), '0);
        end else begin
          oldest = due_results.pop_front();
          if (rsp_mon.status !== oldest.status)
            report_mismatch("status", 32'(rsp_mon.status), 32'(oldest.status));
          if (rsp_mon.out_mass !== oldest.out_mass)
            report_mismatch("out_mass", 32'(rsp_mon.out_mass), 32'(oldest.out_mass));
          if (rsp_mon.out_loader !== oldest.out_loader)
            report_mismatch("out_loader", 32'(rsp_mon.out_loader), 32'(oldest.out_loader));
          if (rsp_mon.occupancy !== oldest.occupancy)
            report_mismatch("occupancy", 32'(rsp_mon.occupancy), 32'(oldest.occupancy));
          if (rsp_mon.held_mass !== oldest.held_mass)
            report_mismatch("held_mass", 32'(rsp_mon.held_mass), 32'(oldest.held_mass));
          if (rsp_mon.credit_left !== oldest.credit_left)
            report_mismatch("credit_left", 32'(rsp_mon.credit_left), 32'(oldest.credit_left));
        end
      end

      if (req_mon.valid && req_mon.ready) begin
        outcome = '0;
        if (req_mon.mode == ModePush) begin
          mass_sum = {1'b0, held_total} + 17'(req_mon.item_mass);
          if (item_count < usable_slots(regs.slots) && mass_sum <= {1'b0, regs.limit}) begin
            shadow_ring[tail_slot] = '{mass: req_mon.item_mass, loader: req_mon.loader_id};
            tail_slot          = next_slot(tail_slot);
            item_count         = item_count + 1'b1;
            held_total         = mass_sum[WideBits-1:0];
            outcome.status     = StPushed;
            outcome.out_mass   = req_mon.item_mass;
            outcome.out_loader = req_mon.loader_id;
          end else begin
            outcome.status = StRefused;
          end
        end else if (item_count == '0) begin
          outcome.status = StEmpty;
        end else begin
          head_item = shadow_ring[head_slot];
          if (WideBits'(head_item.mass) <= credit) begin
            head_slot          = next_slot(head_slot);
            item_count         = item_count - 1'b1;
            held_total         = (held_total >= WideBits'(head_item.mass)) ?
                                 held_total - WideBits'(head_item.mass) : '0;
            credit             = credit - WideBits'(head_item.mass);
            outcome.status     = StPopped;
            outcome.out_mass   = head_item.mass;
            outcome.out_loader = head_item.loader;
          end else begin
            credit         = regs.capacity;
            outcome.status = StSwapped;
          end
        end
        outcome.occupancy   = item_count;
        outcome.held_mass   = held_total;
        outcome.credit_left = credit;
        due_results.push_back(outcome);
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSlots: begin
            regs.slots = cfg_wdata_i[SlotBits-1:0];
            head_slot  = '0;
            tail_slot  = '0;
            item_count = '0;
            held_total = '0;
          end
          CfgLimit: regs.limit = cfg_wdata_i;
          CfgCapacity: begin
            regs.capacity = cfg_wdata_i;
            credit        = cfg_wdata_i;
          end
          default: ;
        endcase
      end

      pending_o <= due_results.size();
    end
  end

endmodule

// File: dv/tb_weight_limited_fifo_with_consumer_credit.sv
// ----------------------------------------------------------------------------
// tb_weight_limited_fifo_with_consumer_credit
// Drives push and pop requests into the weight limited FIFO through a series
// of slot count, weight limit and capacity settings: a directed opening over
// the corner cases, then random traffic with random gaps and back-pressure,
// including one long response stall. The checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_weight_limited_fifo_with_consumer_credit;
  timeunit 1ns;
  timeprecision 1ps;

  import wlf_pkg::*;

  localparam int         CycleLimit = 1_000_000;
  localparam int         LongHold   = 300;
  localparam int         PhaseItems = 150;
  localparam int         NumPhases  = 11;
  localparam logic [1:0] CfgUnused  = 2'd3;

  localparam int PhaseSlots [NumPhases] = '{16, 4, 1, 0, 31, 17, 2, 8, 16, 5, 12};
  localparam int PhaseLimit [NumPhases] =
    '{65535, 600, 255, 100, 2000, 30000, 0, 1500, 4080, 300, 65535};
  localparam int PhaseCap [NumPhases] =
    '{65535, 1000, 255, 0, 3000, 5000, 65535, 700, 65535, 255, 400};

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_idx   = '0;
  logic [WideBits-1:0] cfg_wdata = '0;
  int                  fail_count;
  int                  pending;
  int                  cycles    = 0;
  bit                  calm      = 1'b0;
  bit                  hold_armed = 1'b0;
  bit                  hold_done  = 1'b0;

  wlf_req_if req ();
  wlf_rsp_if rsp ();

  weight_limited_fifo_with_consumer_credit u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  wlf_fifo_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_mon     (req),
    .rsp_mon     (rsp),
    .errors_o    (fail_count),
    .pending_o   (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("weight_limited_fifo_with_consumer_credit test failed");
      $finish;
    end
  end

  initial begin : rsp_sink
    rsp.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_armed && !hold_done) begin
        rsp.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (calm || $urandom_range(99) < 60) begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(40, 1)) @(posedge clk_i);
      end else begin
        rsp.ready <= 1'b0;
        repeat (($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(3, 1))
          @(posedge clk_i);
      end
    end
  end

  task automatic send_req(input logic op, input logic [MassBits-1:0] mass,
                          input logic [LoaderBits-1:0] loader);
    int gap;
    int pick;
    pick = $urandom_range(99);
    if (calm || pick < 55) gap = 0;
    else if (pick < 90) gap = $urandom_range(3, 1);
    else gap = $urandom_range(30, 8);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.mode      <= op;
    req.item_mass <= mass;
    req.loader_id <= loader;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [WideBits-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [MassBits-1:0] mass;
    int                  push_pct;
    req.valid     <= 1'b0;
    req.mode      <= ModePush;
    req.item_mass <= '0;
    req.loader_id <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty pop, extreme masses and ids, drain back to empty
    send_req(ModePop, '0, '0);
    send_req(ModePush, 8'h00, 22'h000000);
    send_req(ModePush, 8'hFF, 22'h3FFFFF);
    send_req(ModePush, 8'hAA, 22'h155555);
    send_req(ModePush, 8'h55, 22'h2AAAAA);
    repeat (5) send_req(ModePop, '1, '1);

    // two slots, tight limit, capacity below the heaviest item
    write_reg(CfgSlots, 16'd2);
    write_reg(CfgLimit, 16'd300);
    write_reg(CfgCapacity, 16'd200);
    send_req(ModePush, 8'd255, 22'h0F0F0F);
    send_req(ModePush, 8'd45, 22'h30F0F0);
    send_req(ModePush, 8'd1, 22'h000001);
    send_req(ModePop, '0, '0);
    send_req(ModePop, '0, '0);

    // reload credit, then lower the limit below the held mass
    write_reg(CfgCapacity, 16'hFFFF);
    send_req(ModePop, '0, '0);
    write_reg(CfgLimit, 16'd10);
    send_req(ModePush, 8'd0, 22'h123456);
    send_req(ModePop, '0, '0);
    send_req(ModePush, 8'd10, 22'h2BCDEF);

    // zero capacity, then a slot count of zero
    write_reg(CfgCapacity, 16'd0);
    send_req(ModePop, '0, '0);
    write_reg(CfgSlots, 16'd0);
    send_req(ModePush, 8'd0, 22'h3A5A5A);
    send_req(ModePush, 8'd0, 22'h05A5A5);
    send_req(ModePop, '0, '0);

    for (int p = 0; p < NumPhases; p++) begin
      write_reg(CfgSlots, WideBits'(PhaseSlots[p]));
      write_reg(CfgLimit, WideBits'(PhaseLimit[p]));
      write_reg(CfgCapacity, WideBits'(PhaseCap[p]));
      if (p == 2) write_reg(CfgUnused, WideBits'($urandom));
      calm = (p == 4);
      if (p == 1) hold_armed = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        push_pct = ((i / 20) % 2 != 0) ? 35 : 70;
        if (p == 1 && !hold_done) push_pct = 80;
        case ($urandom_range(9))
          0:       mass = '0;
          1:       mass = '1;
          2:       mass = MassBits'($urandom_range(15));
          default: mass = MassBits'($urandom);
        endcase
        send_req(($urandom_range(99) < push_pct) ? ModePush : ModePop, mass,
                 LoaderBits'($urandom));
      end
    end

    calm = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("weight_limited_fifo_with_consumer_credit test passed");
    end else begin
      $display("weight_limited_fifo_with_consumer_credit test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/wlf_pkg.sv
design/wlf_req_if.sv
design/wlf_rsp_if.sv
design/wlf_ring_mem.sv
design/wlf_queue_ctrl.sv
design/weight_limited_fifo_with_consumer_credit.sv
dv/wlf_fifo_checker.sv
dv/tb_weight_limited_fifo_with_consumer_credit.sv
